### sv/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants of the tile cover enumerator.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int COORD_W        = 13;
	localparam int IDX_W          = 6;
	localparam int LIM_W          = 17;
	localparam int DIV_W          = COORD_W;
	localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int PROD_W         = 2 * COORD_W;
	localparam int DEF_MAX_TILES  = 64;
	localparam int DEF_COORD_BITS = 12;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPLIT_ROWS    = 2'd0,
		CFG_SPLIT_COLS    = 2'd1,
		CFG_COLUMN_EXTENT = 2'd2,
		CFG_TWO_DIMS      = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_ROW_LO,
		OP_ROW_HI,
		OP_COL_LO,
		OP_COL_HI,
		OP_TPR
	} div_op_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_DIV_START,
		SQ_DIV_WAIT,
		SQ_MUL_HI,
		SQ_CHECK,
		SQ_MUL_LO,
		SQ_SETUP,
		SQ_EMIT,
		SQ_SINGLE
	} seq_state_t;

	// Effective configuration; split sizes are already forced to at least one.
	typedef struct packed {
		logic [COORD_W-1:0] split_rows;
		logic [COORD_W-1:0] split_cols;
		logic [COORD_W-1:0] column_extent;
		logic               two_dims;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage

### sv/tce_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_if
// Valid/ready channels of the tile cover enumerator: input ranges, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface tce_in_if;
	logic                        valid;
	logic                        ready;
	logic [tce_pkg::COORD_W-1:0] row_begin;
	logic [tce_pkg::COORD_W-1:0] row_end;
	logic [tce_pkg::COORD_W-1:0] col_begin;
	logic [tce_pkg::COORD_W-1:0] col_end;

	modport source (output valid, row_begin, row_end, col_begin, col_end, input ready);
	modport sink (input valid, row_begin, row_end, col_begin, col_end, output ready);
endinterface

interface tce_out_if;
	logic                      valid;
	logic                      ready;
	logic [tce_pkg::IDX_W-1:0] tile_index;
	tce_pkg::status_t          status;
	logic                      last;

	modport source (output valid, tile_index, status, last, input ready);
	modport sink (input valid, tile_index, status, last, output ready);
endinterface

interface tce_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tce_pkg::CFG_IDX_W-1:0] index;
	logic [tce_pkg::COORD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/tile_cover_enumerator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_cover_enumerator_core
// Enumerates the linear indices of all tiles touched by a 1-D or 2-D range.
// ----------------------------------------------------------------------------
// Usage: write split_rows, split_cols, column_extent and two_dims through the
// cfg channel (always ready) while the block is idle. Each transaction on the
// item channel carries one range [begin,end). The result channel returns the
// covering tile indices in raster order, last marking the final one; a range
// that is empty or too large returns one result with status empty or range.
// Timing: one shared divider does all divisions; a 2-D range needs five
// divisions and a 1-D range two, followed by the multiply, check and setup
// states before the first result. Results then follow one per cycle while the
// receiver is ready. The single result of an empty or oversize range passes
// through the SINGLE state into the registered result stage.
// Item ready is high only while no range is being worked on. A stalled
// receiver holds the registered result and stops the index generator; nothing
// is dropped. Reset clears the sequencer and output valid and returns the
// registers to split sizes of one, extent zero, 1-D.
// ----------------------------------------------------------------------------
module tile_cover_enumerator_core #(
	parameter int MAX_TILES  = tce_pkg::DEF_MAX_TILES,
	parameter int COORD_BITS = tce_pkg::DEF_COORD_BITS
) (
	input logic       clk,
	input logic       arst_n,
	tce_cfg_if.sink   cfg,
	tce_in_if.sink    item,
	tce_out_if.source result
);
	import tce_pkg::*;

	logic [COORD_W-1:0] split_rows_q, split_cols_q, column_extent_q;
	logic               two_dims_q;
	cfg_t               cfg_eff;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_rows_q    <= COORD_W'(1);
			split_cols_q    <= COORD_W'(1);
			column_extent_q <= '0;
			two_dims_q      <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SPLIT_ROWS:    split_rows_q    <= cfg.data;
				CFG_SPLIT_COLS:    split_cols_q    <= cfg.data;
				CFG_COLUMN_EXTENT: column_extent_q <= cfg.data;
				CFG_TWO_DIMS:      two_dims_q      <= cfg.data[0];
				default:           ;
			endcase
		end
	end

	// A split size of zero behaves as one.
	always_comb begin
		cfg_eff.split_rows    = (split_rows_q == '0) ? COORD_W'(1) : split_rows_q;
		cfg_eff.split_cols    = (split_cols_q == '0) ? COORD_W'(1) : split_cols_q;
		cfg_eff.column_extent = column_extent_q;
		cfg_eff.two_dims      = two_dims_q;
	end

	tce_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tce_sequencer #(
		.MAX_TILES  (MAX_TILES),
		.COORD_BITS (COORD_BITS)
	) u_sequencer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_eff),
		.item    (item),
		.result  (result),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

endmodule

### sv/tce_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by all the
// floor and ceiling divisions of the enumerator.
// ----------------------------------------------------------------------------
module tce_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tce_pkg::div_req_t req,
	output tce_pkg::div_rsp_t rsp
);
	import tce_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     div_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 sub_ok;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign sub_ok  = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend is shifted out of the quotient register as quotient bits
	// are shifted in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], sub_ok};
			rem_q <= sub_ok ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

### sv/tce_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_sequencer
// Range checks, division sequencing, overflow checks and raster-order tile
// index generation into a registered result stage.
// ----------------------------------------------------------------------------
module tce_sequencer #(
	parameter int MAX_TILES  = tce_pkg::DEF_MAX_TILES,
	parameter int COORD_BITS = tce_pkg::DEF_COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tce_pkg::cfg_t     cfg,
	tce_in_if.sink            item,
	tce_out_if.source         result,
	output tce_pkg::div_req_t div_req,
	input  tce_pkg::div_rsp_t div_rsp
);
	import tce_pkg::*;

	localparam logic [LIM_W-1:0]  Limit   = LIM_W'(1) << COORD_BITS;
	localparam logic [PROD_W:0]   MaxIdx  = (PROD_W + 1)'(MAX_TILES);

	seq_state_t         state_q, state_d;
	div_op_t            op_q;
	logic [COORD_W-1:0] rb_q, re_q, cb_q, ce_q;
	logic               dual_q;
	logic [COORD_W-1:0] r0_q, r1_q, c0_q, c1_q, tpr_q;
	logic [COORD_W-1:0] i_q, j_q;
	logic [PROD_W-1:0]  prod_q;
	logic [IDX_W-1:0]   idx_q, base_q;
	status_t            single_st_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	status_t            out_st_q;
	logic               out_last_q;

	logic               accept, bad, empty, slot_free, row_done, last_now;
	logic               range_fail, div_last;
	logic [COORD_W-1:0] quo_adj, mul_a;
	logic [PROD_W-1:0]  mul_p;
	logic [PROD_W:0]    top_idx;

	assign accept    = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;

	always_comb begin
		bad = LIM_W'(item.row_begin) > Limit || LIM_W'(item.row_end) > Limit;
		if (cfg.two_dims && (LIM_W'(item.col_begin) > Limit || LIM_W'(item.col_end) > Limit
				|| LIM_W'(cfg.column_extent) > Limit)) begin
			bad = 1'b1;
		end
		empty = item.row_begin >= item.row_end
			|| (cfg.two_dims && item.col_begin >= item.col_end);
	end

	// Every division but the lower row and column bound rounds up.
	assign quo_adj = div_rsp.quotient
		+ COORD_W'(op_q != OP_ROW_LO && op_q != OP_COL_LO && div_rsp.remainder != '0);
	assign div_last = op_q == OP_TPR || (op_q == OP_ROW_HI && !dual_q);

	assign mul_a    = (state_q == SQ_MUL_HI) ? r1_q - COORD_W'(1) : r0_q;
	assign mul_p    = mul_a * tpr_q;
	assign top_idx  = {1'b0, prod_q} + (PROD_W + 1)'(c1_q - COORD_W'(1));
	assign range_fail = (dual_q && c1_q > tpr_q) || top_idx >= MaxIdx;

	assign row_done = j_q + COORD_W'(1) == c1_q;
	assign last_now = row_done && (i_q + COORD_W'(1) == r1_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE:      if (accept) state_d = (bad || empty) ? SQ_SINGLE : SQ_DIV_START;
			SQ_DIV_START: state_d = SQ_DIV_WAIT;
			SQ_DIV_WAIT:  if (div_rsp.done) state_d = div_last ? SQ_MUL_HI : SQ_DIV_START;
			SQ_MUL_HI:    state_d = SQ_CHECK;
			SQ_CHECK:     state_d = range_fail ? SQ_SINGLE : SQ_MUL_LO;
			SQ_MUL_LO:    state_d = SQ_SETUP;
			SQ_SETUP:     state_d = SQ_EMIT;
			SQ_EMIT:      if (slot_free && last_now) state_d = SQ_IDLE;
			SQ_SINGLE:    if (slot_free) state_d = SQ_IDLE;
			default:      state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		item.ready       = state_q == SQ_IDLE;
		div_req.start    = state_q == SQ_DIV_START;
		div_req.divisor  = (op_q == OP_ROW_LO || op_q == OP_ROW_HI) ? cfg.split_rows
			: cfg.split_cols;
		case (op_q)
			OP_ROW_LO: div_req.dividend = rb_q;
			OP_ROW_HI: div_req.dividend = re_q;
			OP_COL_LO: div_req.dividend = cb_q;
			OP_COL_HI: div_req.dividend = ce_q;
			OP_TPR:    div_req.dividend = cfg.column_extent;
			default:   div_req.dividend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			op_q        <= OP_ROW_LO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_IDLE) begin
				op_q <= OP_ROW_LO;
			end else if (state_q == SQ_DIV_WAIT && div_rsp.done) begin
				op_q <= div_op_t'(op_q + 3'd1);
			end
			if ((state_q == SQ_EMIT || state_q == SQ_SINGLE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rb_q        <= item.row_begin;
			re_q        <= item.row_end;
			cb_q        <= item.col_begin;
			ce_q        <= item.col_end;
			dual_q      <= cfg.two_dims;
			single_st_q <= bad ? ST_RANGE : ST_EMPTY;
		end
		if (state_q == SQ_DIV_WAIT && div_rsp.done) begin
			case (op_q)
				OP_ROW_LO: r0_q <= quo_adj;
				OP_ROW_HI: begin
					r1_q <= quo_adj;
					if (!dual_q) begin
						c0_q  <= '0;
						c1_q  <= COORD_W'(1);
						tpr_q <= COORD_W'(1);
					end
				end
				OP_COL_LO: c0_q  <= quo_adj;
				OP_COL_HI: c1_q  <= quo_adj;
				OP_TPR:    tpr_q <= quo_adj;
				default:   ;
			endcase
		end
		if (state_q == SQ_MUL_HI || state_q == SQ_MUL_LO) begin
			prod_q <= mul_p;
		end
		if (state_q == SQ_CHECK) begin
			single_st_q <= ST_RANGE;
		end
		if (state_q == SQ_SETUP) begin
			i_q    <= r0_q;
			j_q    <= c0_q;
			idx_q  <= prod_q[IDX_W-1:0] + c0_q[IDX_W-1:0];
			base_q <= prod_q[IDX_W-1:0] + c0_q[IDX_W-1:0];
		end
		if (state_q == SQ_EMIT && slot_free) begin
			out_idx_q  <= idx_q;
			out_st_q   <= ST_OK;
			out_last_q <= last_now;
			if (row_done) begin
				i_q    <= i_q + COORD_W'(1);
				j_q    <= c0_q;
				idx_q  <= base_q + tpr_q[IDX_W-1:0];
				base_q <= base_q + tpr_q[IDX_W-1:0];
			end else begin
				j_q   <= j_q + COORD_W'(1);
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (state_q == SQ_SINGLE && slot_free) begin
			out_idx_q  <= '0;
			out_st_q   <= single_st_q;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tile_index = out_idx_q;
	assign result.status     = out_st_q;
	assign result.last       = out_last_q;

endmodule
